// ===== rtl/vas_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Voice allocator package
// Sizes, operation/status/command codes and the controller-datapath structs.
// ----------------------------------------------------------------------------
package vas_pkg;

  localparam int VOICES   = 16;
  localparam int BUFFERS  = 16;
  localparam int VIDX_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int HANDLE_W = 32;
  localparam int STAMP_W  = 32;
  localparam int CNT_W    = 5;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // first handle issued after reset and after a wrap
  localparam logic [HANDLE_W-1:0] HANDLE_FIRST = HANDLE_W'(1);

  // request actions
  localparam logic [2:0] ACT_PLAY   = 3'd0;
  localparam logic [2:0] ACT_STOP   = 3'd1;
  localparam logic [2:0] ACT_PAUSE  = 3'd2;
  localparam logic [2:0] ACT_RESUME = 3'd3;
  localparam logic [2:0] ACT_REWIND = 3'd4;
  localparam logic [2:0] ACT_QUERY  = 3'd5;
  localparam logic [2:0] ACT_COUNT  = 3'd6;
  localparam logic [2:0] ACT_ENDED  = 3'd7;

  // result status
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_READY = 3'd1;
  localparam logic [2:0] ST_NO_NAME   = 3'd2;
  localparam logic [2:0] ST_NO_VOICE  = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;

  // voice engine commands
  localparam logic [2:0] VC_NONE    = 3'd0;
  localparam logic [2:0] VC_START   = 3'd1;
  localparam logic [2:0] VC_RELEASE = 3'd2;
  localparam logic [2:0] VC_PAUSE   = 3'd3;
  localparam logic [2:0] VC_RESUME  = 3'd4;
  localparam logic [2:0] VC_REWIND  = 3'd5;

  typedef logic [VIDX_W-1:0] vidx_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic step;
    logic apply;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/vas_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Voice allocator channels
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vas_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] handle;
  logic [3:0]  buffer_slot;
  logic        name_found;
  logic [15:0] gain;
  logic        looping;
  logic        keep;
  logic [3:0]  ended_voice;

  modport source (output valid, action, handle, buffer_slot, name_found, gain,
                  looping, keep, ended_voice, input ready);
  modport sink (input valid, action, handle, buffer_slot, name_found, gain,
                looping, keep, ended_voice, output ready);
endinterface

interface vas_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] handle_out;
  logic [3:0]  voice_index;
  logic [2:0]  voice_command;
  logic [3:0]  buffer_out;
  logic [15:0] gain_out;
  logic        loop_out;
  logic        finished;
  logic [4:0]  playing_count;

  modport source (output valid, status, handle_out, voice_index, voice_command,
                  buffer_out, gain_out, loop_out, finished, playing_count,
                  input ready);
  modport sink (input valid, status, handle_out, voice_index, voice_command,
                buffer_out, gain_out, loop_out, finished, playing_count,
                output ready);
endinterface

interface vas_cfg_if;
  logic valid;
  logic ready;
  logic audio_ready;

  modport source (output valid, audio_ready, input ready);
  modport sink (input valid, audio_ready, output ready);
endinterface
`default_nettype wire

// ===== rtl/vas_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Voice allocator controller
// Sequences capture, table scan and apply for one request at a time.
// ----------------------------------------------------------------------------
module vas_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  vas_pkg::dp_sts_t    sts,
  output vas_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} state_t;

  state_t state;

  // advance through idle, scan and apply
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) state <= S_SCAN;
        end
        S_SCAN: begin
          if (sts.scan_last) state <= S_APPLY;
        end
        S_APPLY: begin
          if (!sts.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // decode commands; hold apply while the result register is full and not being taken
  always_comb begin
    req_ready   = (state == S_IDLE);
    cmd.capture = req_ready && req_valid;
    cmd.step    = (state == S_SCAN);
    cmd.apply   = (state == S_APPLY) && !sts.out_busy;
  end

endmodule
`default_nettype wire

// ===== rtl/vas_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Voice allocator datapath
// Voice table, one-voice-per-cycle scan, apply logic and result register.
// ----------------------------------------------------------------------------
module vas_dp (
  input  logic               clk,
  input  logic               rst,
  input  vas_pkg::ctrl_cmd_t cmd,
  output vas_pkg::dp_sts_t   sts,
  input  logic [2:0]         action,
  input  logic [31:0]        handle,
  input  logic [3:0]         buffer_slot,
  input  logic               name_found,
  input  logic [15:0]        gain,
  input  logic               looping,
  input  logic               keep,
  input  logic [3:0]         ended_voice,
  vas_cfg_if.sink            cfg,
  vas_rsp_if.source          rsp
);

  // captured request
  logic [2:0]  r_action;
  logic [31:0] r_handle;
  logic [3:0]  r_buffer;
  logic        r_found;
  logic [15:0] r_gain;
  logic        r_loop;
  logic        r_keep;
  logic [3:0]  r_ended;

  logic audio_ready;

  // voice table
  logic [vas_pkg::HANDLE_W-1:0] owner [vas_pkg::VOICES];
  logic [vas_pkg::STAMP_W-1:0]  stamp [vas_pkg::VOICES];
  logic [vas_pkg::VOICES-1:0]   kept;
  logic [vas_pkg::VOICES-1:0]   loaded;
  logic [vas_pkg::VOICES-1:0]   sounding;

  logic [vas_pkg::HANDLE_W-1:0] handle_counter;
  logic [vas_pkg::HANDLE_W-1:0] handle_counter_next;
  logic [vas_pkg::STAMP_W-1:0]  stamp_counter;

  // scan state
  vas_pkg::vidx_t              scan_idx;
  logic                        pick_hit;
  vas_pkg::vidx_t              pick_idx;
  logic                        old_hit;
  vas_pkg::vidx_t              old_idx;
  logic [vas_pkg::STAMP_W-1:0] old_stamp;
  logic                        look_hit;
  vas_pkg::vidx_t              look_idx;
  logic                        look_loaded;
  logic                        look_playing;
  logic [vas_pkg::CNT_W-1:0]   count;

  logic [vas_pkg::HANDLE_W-1:0] cur_owner;
  logic [vas_pkg::STAMP_W-1:0]  cur_stamp;
  logic                         cur_kept;
  logic                         cur_loaded;
  logic                         cur_playing;

  // apply results
  logic [2:0]                   n_status;
  logic [31:0]                  n_handle;
  vas_pkg::vidx_t               n_vidx;
  logic [2:0]                   n_cmd;
  logic [3:0]                   n_buf;
  logic [15:0]                  n_gain;
  logic                         n_loop;
  logic                         n_fin;
  logic [vas_pkg::CNT_W-1:0]    n_cnt;
  logic                         we_main;
  logic                         we_snd;
  logic                         we_stamp;
  logic                         bump;
  vas_pkg::vidx_t               w_idx;
  vas_pkg::vidx_t               play_idx;
  logic [vas_pkg::HANDLE_W-1:0] w_owner;
  logic                         w_kept;
  logic                         w_loaded;
  logic                         w_snd;
  logic                         buf_ok;
  logic                         ended_ok;

  // result register
  logic        o_valid;
  logic [2:0]  o_status;
  logic [31:0] o_handle;
  logic [3:0]  o_vidx;
  logic [2:0]  o_cmd;
  logic [3:0]  o_buf;
  logic [15:0] o_gain;
  logic        o_loop;
  logic        o_fin;
  logic [4:0]  o_cnt;

  // capture the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_action <= action;
      r_handle <= handle;
      r_buffer <= buffer_slot;
      r_found  <= name_found;
      r_gain   <= gain;
      r_loop   <= looping;
      r_keep   <= keep;
      r_ended  <= ended_voice;
    end
  end

  // configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      audio_ready <= 1'b0;
    end else if (cfg.valid) begin
      audio_ready <= cfg.audio_ready;
    end
  end

  // read the voice under the scan pointer
  always_comb begin
    cur_owner   = owner[scan_idx];
    cur_stamp   = stamp[scan_idx];
    cur_kept    = kept[scan_idx];
    cur_loaded  = loaded[scan_idx];
    cur_playing = loaded[scan_idx] && sounding[scan_idx];
  end

  assign sts.scan_last = (scan_idx == vas_pkg::vidx_t'(vas_pkg::VOICES - 1));
  assign sts.out_busy  = o_valid && !rsp.ready;

  // scan: free pick, oldest steal candidate, handle lookup, playing count
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      pick_hit <= 1'b0;
      old_hit  <= 1'b0;
      look_hit <= 1'b0;
      count    <= '0;
    end else if (cmd.capture) begin
      scan_idx <= '0;
      pick_hit <= 1'b0;
      old_hit  <= 1'b0;
      look_hit <= 1'b0;
      count    <= '0;
    end else if (cmd.step) begin
      scan_idx <= vas_pkg::vidx_t'(scan_idx + 1'b1);
      if (!pick_hit && (cur_owner == '0 || (!cur_kept && !cur_playing))) begin
        pick_hit <= 1'b1;
        pick_idx <= scan_idx;
      end else if (!pick_hit && !cur_kept && (!old_hit || cur_stamp < old_stamp)) begin
        old_hit   <= 1'b1;
        old_idx   <= scan_idx;
        old_stamp <= cur_stamp;
      end
      if (!look_hit && r_handle != '0 && cur_owner == r_handle) begin
        look_hit     <= 1'b1;
        look_idx     <= scan_idx;
        look_loaded  <= cur_loaded;
        look_playing <= cur_playing;
      end
      if (cur_owner != '0 && cur_playing && count != vas_pkg::CNT_MAX) begin
        count <= count + 1'b1;
      end
    end
  end

  // next handle skips zero on wrap
  always_comb begin
    handle_counter_next = handle_counter + 1'b1;
    if (handle_counter_next == '0) handle_counter_next = vas_pkg::HANDLE_FIRST;
  end

  assign buf_ok   = 32'(r_buffer) < 32'(vas_pkg::BUFFERS);
  assign ended_ok = 32'(r_ended) < 32'(vas_pkg::VOICES);
  assign play_idx = pick_hit ? pick_idx : old_idx;

  // decide the result and the table update
  always_comb begin
    n_status = vas_pkg::ST_OK;
    n_handle = '0;
    n_vidx   = '0;
    n_cmd    = vas_pkg::VC_NONE;
    n_buf    = '0;
    n_gain   = '0;
    n_loop   = 1'b0;
    n_fin    = 1'b0;
    n_cnt    = '0;
    we_main  = 1'b0;
    we_snd   = 1'b0;
    we_stamp = 1'b0;
    bump     = 1'b0;
    w_idx    = look_idx;
    w_owner  = '0;
    w_kept   = 1'b0;
    w_loaded = 1'b0;
    w_snd    = 1'b0;
    case (r_action)
      vas_pkg::ACT_PLAY: begin
        if (!audio_ready) begin
          n_status = vas_pkg::ST_NOT_READY;
        end else if (!r_found || !buf_ok) begin
          n_status = vas_pkg::ST_NO_NAME;
        end else if (!pick_hit && !old_hit) begin
          n_status = vas_pkg::ST_NO_VOICE;
        end else begin
          we_main  = 1'b1;
          we_snd   = 1'b1;
          we_stamp = 1'b1;
          bump     = 1'b1;
          w_idx    = play_idx;
          w_owner  = handle_counter;
          w_kept   = r_keep;
          w_loaded = 1'b1;
          w_snd    = 1'b1;
          n_handle = handle_counter;
          n_vidx   = play_idx;
          n_cmd    = vas_pkg::VC_START;
          n_buf    = r_buffer;
          n_gain   = r_gain;
          n_loop   = r_loop;
        end
      end
      vas_pkg::ACT_STOP, vas_pkg::ACT_PAUSE, vas_pkg::ACT_RESUME,
      vas_pkg::ACT_REWIND, vas_pkg::ACT_QUERY: begin
        if (!look_hit) begin
          n_status = vas_pkg::ST_UNKNOWN;
          n_fin    = (r_action == vas_pkg::ACT_QUERY);
        end else begin
          n_vidx = look_idx;
          case (r_action)
            vas_pkg::ACT_STOP: begin
              we_main = 1'b1;
              we_snd  = 1'b1;
              n_cmd   = vas_pkg::VC_RELEASE;
            end
            vas_pkg::ACT_QUERY: begin
              n_fin = !look_playing;
            end
            vas_pkg::ACT_PAUSE: begin
              if (look_loaded) begin
                we_snd = 1'b1;
                n_cmd  = vas_pkg::VC_PAUSE;
              end
            end
            vas_pkg::ACT_RESUME: begin
              if (look_loaded) begin
                we_snd = 1'b1;
                w_snd  = 1'b1;
                n_cmd  = vas_pkg::VC_RESUME;
              end
            end
            vas_pkg::ACT_REWIND: begin
              if (look_loaded) begin
                we_snd = 1'b1;
                n_cmd  = vas_pkg::VC_REWIND;
              end
            end
            default: ;
          endcase
        end
      end
      vas_pkg::ACT_COUNT: begin
        n_cnt = count;
      end
      vas_pkg::ACT_ENDED: begin
        if (ended_ok) begin
          we_snd = 1'b1;
          w_idx  = vas_pkg::vidx_t'(r_ended);
          n_vidx = w_idx;
        end
      end
      default: ;
    endcase
  end

  // update the voice table and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vas_pkg::VOICES; i++) begin
        owner[i] <= '0;
      end
      kept           <= '0;
      loaded         <= '0;
      sounding       <= '0;
      handle_counter <= vas_pkg::HANDLE_FIRST;
      stamp_counter  <= '0;
    end else if (cmd.apply) begin
      if (we_main) begin
        owner[w_idx]  <= w_owner;
        kept[w_idx]   <= w_kept;
        loaded[w_idx] <= w_loaded;
      end
      if (we_snd) sounding[w_idx] <= w_snd;
      if (bump) begin
        handle_counter <= handle_counter_next;
        stamp_counter  <= stamp_counter + 1'b1;
      end
    end
  end

  // start stamps need no reset
  always_ff @(posedge clk) begin
    if (cmd.apply && we_stamp) stamp[w_idx] <= stamp_counter;
  end

  // result register: load on apply, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (cmd.apply) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      o_status <= n_status;
      o_handle <= n_handle;
      o_vidx   <= 4'(n_vidx);
      o_cmd    <= n_cmd;
      o_buf    <= n_buf;
      o_gain   <= n_gain;
      o_loop   <= n_loop;
      o_fin    <= n_fin;
      o_cnt    <= n_cnt;
    end
  end

  assign rsp.valid         = o_valid;
  assign rsp.status        = o_status;
  assign rsp.handle_out    = o_handle;
  assign rsp.voice_index   = o_vidx;
  assign rsp.voice_command = o_cmd;
  assign rsp.buffer_out    = o_buf;
  assign rsp.gain_out      = o_gain;
  assign rsp.loop_out      = o_loop;
  assign rsp.finished      = o_fin;
  assign rsp.playing_count = o_cnt;

endmodule
`default_nettype wire

// ===== rtl/voice_allocator_with_stealing.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Voice allocator with oldest-first stealing
// Hands out playback voices to play requests and tracks their state.
// ----------------------------------------------------------------------------
// Each request is accepted, then the table is scanned a voice per cycle for a
// free voice, the oldest stealable voice, the named handle and the playing
// count, and then the update is applied and the result register loaded; the
// apply waits while the result register is full and not being taken. A finished
// result waits in that register while the next request is accepted and
// scanned. The configuration channel is always ready; write it only while no
// request is in flight. After reset the table is empty and no clearing pass is
// needed.
module voice_allocator_with_stealing (
  input  logic      clk,
  input  logic      rst,
  vas_req_if.sink   req,
  vas_rsp_if.source rsp,
  vas_cfg_if.sink   cfg
);

  vas_pkg::ctrl_cmd_t cmd;
  vas_pkg::dp_sts_t   sts;
  logic               req_ready;

  assign req.ready = req_ready;

  vas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vas_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .action      (req.action),
    .handle      (req.handle),
    .buffer_slot (req.buffer_slot),
    .name_found  (req.name_found),
    .gain        (req.gain),
    .looping     (req.looping),
    .keep        (req.keep),
    .ended_voice (req.ended_voice),
    .cfg         (cfg),
    .rsp         (rsp)
  );

endmodule
`default_nettype wire

// ===== rtl/vas_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Voice allocator port checker
// Watches the top-level channels for ordering and result consistency.
// ----------------------------------------------------------------------------
module vas_chk (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  rsp_status,
  input logic [31:0] rsp_handle_out,
  input logic [2:0]  rsp_voice_command
);

  // a request is scanned before the next one can enter
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted right after another");

  // hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_handle_out))
    else $error("stalled result changed or dropped");

  // a failed request gives no handle and no command
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != vas_pkg::ST_OK |->
      rsp_handle_out == '0 && rsp_voice_command == vas_pkg::VC_NONE)
    else $error("failed request carries handle or command");

  // a started voice always gets a nonzero handle
  a_start_handle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_voice_command == vas_pkg::VC_START |->
      rsp_status == vas_pkg::ST_OK && rsp_handle_out != '0)
    else $error("voice started without a valid handle");

endmodule

bind voice_allocator_with_stealing vas_chk u_vas_chk (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_handle_out    (rsp.handle_out),
  .rsp_voice_command (rsp.voice_command)
);
`default_nettype wire

// ===== tb/sv/voice_allocator_with_stealing_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Voice allocator with stealing: self-checking testbench
// Drives a short scripted run and then phased random requests through the
// request channel while tracking the voice table in a local predictor. Each
// reply is checked field by field against the oldest pending prediction.
// The device-ready register is toggled between phases while nothing is in
// flight. Both channels see random stall bursts until the final stretch.
// ----------------------------------------------------------------------------
module voice_allocator_with_stealing_test;
  import vas_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int LATENCY        = VOICES + 2;
  localparam int PHASES         = 6;
  localparam int ITEMS_PER_PHASE = 222;
  localparam int STEADY_ITEMS   = 150;
  localparam int TIMEOUT_NS     = 2_000_000;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] handle;
    logic [3:0]  buffer_slot;
    logic        name_found;
    logic [15:0] gain;
    logic        looping;
    logic        keep;
    logic [3:0]  ended_voice;
  } voice_request_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [31:0]      handle_out;
    logic [3:0]       voice_index;
    logic [2:0]       voice_command;
    logic [3:0]       buffer_out;
    logic [15:0]      gain_out;
    logic             loop_out;
    logic             finished;
    logic [CNT_W-1:0] playing_count;
  } voice_reply_t;

  typedef struct packed {
    logic           cfg_row;
    logic           cfg_value;
    logic           typed;
    voice_request_t rq;
    voice_reply_t   reply;
  } script_row_t;

  typedef struct {
    logic ready;
    int   keep_pct;
    int   stop_pct;
  } phase_plan_t;

  localparam voice_request_t NO_REQUEST = '0;
  // all-zero reply: status ok, nothing addressed
  localparam voice_reply_t IDLE_REPLY = '0;
  localparam int SCRIPT_ROWS = 26;

  // Scripted opening: device absent, error codes, extremes, every action
  localparam script_row_t directed_script [SCRIPT_ROWS] = '{
    '{1'b0, 1'b0, 1'b1, '{ACT_PLAY, 32'd0, 4'd15, 1'b1, 16'hFFFF, 1'b1, 1'b1, 4'd0},
      '{ST_NOT_READY, 32'd0, 4'd0, VC_NONE, 4'd0, 16'd0, 1'b0, 1'b0, 5'd0}},
    '{1'b0, 1'b0, 1'b1, '{ACT_COUNT, 32'd0, 4'd0, 1'b0, 16'd0, 1'b0, 1'b0, 4'd0},
      IDLE_REPLY},
    '{1'b0, 1'b0, 1'b1, '{ACT_QUERY, 32'd0, 4'd0, 1'b0, 16'd0, 1'b0, 1'b0, 4'd0},
      '{ST_UNKNOWN, 32'd0, 4'd0, VC_NONE, 4'd0, 16'd0, 1'b0, 1'b1, 5'd0}},
    '{1'b0, 1'b0, 1'b1, '{ACT_STOP, 32'hFFFF_FFFF, 4'd0, 1'b0, 16'd0, 1'b0, 1'b0, 4'd0},
      '{ST_UNKNOWN, 32'd0, 4'd0, VC_NONE, 4'd0, 16'd0, 1'b0, 1'b0, 5'd0}},
    '{1'b1, 1'b1, 1'b0, NO_REQUEST, IDLE_REPLY},
    '{1'b0, 1'b0, 1'b1, '{ACT_PLAY, 32'd0, 4'd7, 1'b0, 16'h1234, 1'b0, 1'b0, 4'd0},
      '{ST_NO_NAME, 32'd0, 4'd0, VC_NONE, 4'd0, 16'd0, 1'b0, 1'b0, 5'd0}},
    '{1'b0, 1'b0, 1'b1, '{ACT_PLAY, 32'd0, 4'd15, 1'b1, 16'hFFFF, 1'b1, 1'b0, 4'd0},
      '{ST_OK, 32'd1, 4'd0, VC_START, 4'd15, 16'hFFFF, 1'b1, 1'b0, 5'd0}},
    '{1'b0, 1'b0, 1'b1, '{ACT_PLAY, 32'd0, 4'd0, 1'b1, 16'd0, 1'b0, 1'b1, 4'd15},
      '{ST_OK, 32'd2, 4'd1, VC_START, 4'd0, 16'd0, 1'b0, 1'b0, 5'd0}},
    '{1'b0, 1'b0, 1'b1, '{ACT_PAUSE, 32'd1, 4'd0, 1'b0, 16'd0, 1'b0, 1'b0, 4'd0},
      '{ST_OK, 32'd0, 4'd0, VC_PAUSE, 4'd0, 16'd0, 1'b0, 1'b0, 5'd0}},
    '{1'b0, 1'b0, 1'b1, '{ACT_QUERY, 32'd1, 4'd0, 1'b0, 16'd0, 1'b0, 1'b0, 4'd0},
      '{ST_OK, 32'd0, 4'd0, VC_NONE, 4'd0, 16'd0, 1'b0, 1'b1, 5'd0}},
    '{1'b0, 1'b0, 1'b1, '{ACT_RESUME, 32'd1, 4'd0, 1'b0, 16'd0, 1'b0, 1'b0, 4'd0},
      '{ST_OK, 32'd0, 4'd0, VC_RESUME, 4'd0, 16'd0, 1'b0, 1'b0, 5'd0}},
    '{1'b0, 1'b0, 1'b1, '{ACT_COUNT, 32'd0, 4'd0, 1'b0, 16'd0, 1'b0, 1'b0, 4'd0},
      '{ST_OK, 32'd0, 4'd0, VC_NONE, 4'd0, 16'd0, 1'b0, 1'b0, 5'd2}},
    '{1'b0, 1'b0, 1'b1, '{ACT_REWIND, 32'd1, 4'd0, 1'b0, 16'd0, 1'b0, 1'b0, 4'd0},
      '{ST_OK, 32'd0, 4'd0, VC_REWIND, 4'd0, 16'd0, 1'b0, 1'b0, 5'd0}},
    '{1'b0, 1'b0, 1'b1, '{ACT_ENDED, 32'd0, 4'd0, 1'b0, 16'd0, 1'b0, 1'b0, 4'd1},
      '{ST_OK, 32'd0, 4'd1, VC_NONE, 4'd0, 16'd0, 1'b0, 1'b0, 5'd0}},
    '{1'b0, 1'b0, 1'b1, '{ACT_COUNT, 32'd0, 4'd0, 1'b0, 16'd0, 1'b0, 1'b0, 4'd0},
      IDLE_REPLY},
    // idle, unkept voice 0 is reused before any unowned voice further up
    '{1'b0, 1'b0, 1'b0, '{ACT_PLAY, 32'd0, 4'd3, 1'b1, 16'h8000, 1'b0, 1'b1, 4'd0},
      IDLE_REPLY},
    '{1'b0, 1'b0, 1'b0, '{ACT_QUERY, 32'd1, 4'd0, 1'b0, 16'd0, 1'b0, 1'b0, 4'd0},
      IDLE_REPLY},
    '{1'b0, 1'b0, 1'b0, '{ACT_STOP, 32'd2, 4'd0, 1'b0, 16'd0, 1'b0, 1'b0, 4'd0},
      IDLE_REPLY},
    '{1'b0, 1'b0, 1'b1, '{ACT_ENDED, 32'd0, 4'd0, 1'b0, 16'd0, 1'b0, 1'b0, 4'd15},
      '{ST_OK, 32'd0, 4'd15, VC_NONE, 4'd0, 16'd0, 1'b0, 1'b0, 5'd0}},
    '{1'b0, 1'b0, 1'b1, '{ACT_RESUME, 32'h8000_0000, 4'd0, 1'b0, 16'd0, 1'b0, 1'b0, 4'd0},
      '{ST_UNKNOWN, 32'd0, 4'd0, VC_NONE, 4'd0, 16'd0, 1'b0, 1'b0, 5'd0}},
    '{1'b0, 1'b0, 1'b0, '{ACT_REWIND, 32'd3, 4'd0, 1'b0, 16'd0, 1'b0, 1'b0, 4'd0},
      IDLE_REPLY},
    // device loss blocks plays only
    '{1'b1, 1'b0, 1'b0, NO_REQUEST, IDLE_REPLY},
    '{1'b0, 1'b0, 1'b1, '{ACT_PLAY, 32'd0, 4'd1, 1'b1, 16'h0001, 1'b0, 1'b0, 4'd0},
      '{ST_NOT_READY, 32'd0, 4'd0, VC_NONE, 4'd0, 16'd0, 1'b0, 1'b0, 5'd0}},
    '{1'b0, 1'b0, 1'b0, '{ACT_QUERY, 32'd3, 4'd0, 1'b0, 16'd0, 1'b0, 1'b0, 4'd0},
      IDLE_REPLY},
    '{1'b1, 1'b1, 1'b0, NO_REQUEST, IDLE_REPLY},
    '{1'b0, 1'b0, 1'b0, '{ACT_PAUSE, 32'd3, 4'd0, 1'b0, 16'd0, 1'b0, 1'b0, 4'd0},
      IDLE_REPLY}
  };

  // Random phases: device state, share of kept plays, share of stops
  phase_plan_t phase_plan [PHASES] = '{
    '{1'b1, 5, 8},
    '{1'b1, 60, 2},
    '{1'b0, 20, 10},
    '{1'b1, 0, 15},
    '{1'b1, 30, 6},
    '{1'b1, 10, 10}
  };

  logic clk = 1'b0;
  logic rst;

  vas_req_if req_ch ();
  vas_rsp_if rsp_ch ();
  vas_cfg_if cfg_ch ();

  voice_allocator_with_stealing DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predicted voice table
  logic [31:0]      owner_tbl    [VOICES];
  logic             kept_tbl     [VOICES];
  logic             loaded_tbl   [VOICES];
  logic             sounding_tbl [VOICES];
  logic [STAMP_W-1:0] stamp_tbl  [VOICES];
  logic [HANDLE_W-1:0] model_handle;
  logic [STAMP_W-1:0]  next_stamp;
  logic                model_audio_ready;

  voice_reply_t pending_replies [$];
  int           mismatch_count;
  logic         steady_tail;

  // Advance the voice table by one request and return its reply
  function automatic voice_reply_t predict_voice_reply(input voice_request_t rq);
    voice_reply_t rp;
    int           i;
    int           v;
    int           oldest;
    int           cnt;
    rp = IDLE_REPLY;
    v = -1;
    oldest = -1;
    cnt = 0;
    case (rq.action)
      ACT_PLAY: begin
        if (!model_audio_ready) begin
          rp.status = ST_NOT_READY;
        end else if (!rq.name_found || rq.buffer_slot >= BUFFERS) begin
          rp.status = ST_NO_NAME;
        end else begin
          // first unowned or idle unkept voice, else the oldest unkept one
          for (i = 0; i < VOICES; i++) begin
            if (v < 0) begin
              if (owner_tbl[i] == '0) begin
                v = i;
              end else if (!kept_tbl[i]) begin
                if (!(loaded_tbl[i] && sounding_tbl[i])) begin
                  v = i;
                end else if (oldest < 0 || stamp_tbl[i] < stamp_tbl[oldest]) begin
                  oldest = i;
                end
              end
            end
          end
          if (v < 0) v = oldest;
          if (v < 0) begin
            rp.status = ST_NO_VOICE;
          end else begin
            owner_tbl[v]    = model_handle;
            kept_tbl[v]     = rq.keep;
            loaded_tbl[v]   = 1'b1;
            sounding_tbl[v] = 1'b1;
            stamp_tbl[v]    = next_stamp;
            next_stamp      = next_stamp + 1'b1;
            rp.handle_out   = model_handle;
            model_handle    = model_handle + 1'b1;
            if (model_handle == '0) model_handle = HANDLE_FIRST;
            rp.voice_index   = vidx_t'(v);
            rp.voice_command = VC_START;
            rp.buffer_out    = rq.buffer_slot;
            rp.gain_out      = rq.gain;
            rp.loop_out      = rq.looping;
          end
        end
      end
      ACT_STOP, ACT_PAUSE, ACT_RESUME, ACT_REWIND, ACT_QUERY: begin
        if (rq.handle != '0) begin
          for (i = 0; i < VOICES; i++) begin
            if (v < 0 && owner_tbl[i] == rq.handle) v = i;
          end
        end
        if (v < 0) begin
          rp.status = ST_UNKNOWN;
          rp.finished = (rq.action == ACT_QUERY);
        end else begin
          rp.voice_index = vidx_t'(v);
          if (rq.action == ACT_STOP) begin
            owner_tbl[v]    = '0;
            kept_tbl[v]     = 1'b0;
            loaded_tbl[v]   = 1'b0;
            sounding_tbl[v] = 1'b0;
            rp.voice_command = VC_RELEASE;
          end else if (rq.action == ACT_QUERY) begin
            rp.finished = !(loaded_tbl[v] && sounding_tbl[v]);
          end else if (loaded_tbl[v]) begin
            sounding_tbl[v] = (rq.action == ACT_RESUME);
            case (rq.action)
              ACT_PAUSE:  rp.voice_command = VC_PAUSE;
              ACT_RESUME: rp.voice_command = VC_RESUME;
              default:    rp.voice_command = VC_REWIND;
            endcase
          end
        end
      end
      ACT_COUNT: begin
        for (i = 0; i < VOICES; i++) begin
          if (owner_tbl[i] != '0 && loaded_tbl[i] && sounding_tbl[i]) cnt++;
        end
        rp.playing_count = (cnt > CNT_MAX) ? CNT_MAX : cnt[CNT_W-1:0];
      end
      ACT_ENDED: begin
        if (rq.ended_voice < VOICES) begin
          sounding_tbl[rq.ended_voice] = 1'b0;
          rp.voice_index = rq.ended_voice;
        end
      end
      default: ;
    endcase
    return rp;
  endfunction

  // Mostly live handles, some stale ones, a few arbitrary words
  function automatic logic [31:0] pick_handle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return owner_tbl[$urandom_range(0, VOICES - 1)];
    if (r < 90) return model_handle - $urandom_range(1, 40);
    return $urandom();
  endfunction

  function automatic voice_request_t random_request(input int keep_pct, input int stop_pct);
    voice_request_t rq;
    int             r;
    rq.action      = ACT_PLAY;
    rq.handle      = $urandom();
    rq.buffer_slot = $urandom_range(0, 15);
    rq.name_found  = ($urandom_range(0, 15) != 0);
    rq.gain        = $urandom_range(0, 65535);
    rq.looping     = $urandom_range(0, 1);
    rq.keep        = ($urandom_range(0, 99) < keep_pct);
    rq.ended_voice = $urandom_range(0, 15);
    r = $urandom_range(0, 99);
    if (r < 4) begin
      // noise: any action, any handle, any name result
      rq.action     = $urandom_range(ACT_PLAY, ACT_ENDED);
      rq.name_found = $urandom_range(0, 1);
    end else if (r >= 44 && r < 44 + stop_pct) begin
      rq.action = ACT_STOP;
      rq.handle = pick_handle();
    end else if (r >= 44) begin
      rq.action = $urandom_range(ACT_PAUSE, ACT_ENDED);
      rq.handle = pick_handle();
    end
    return rq;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, seen);
      mismatch_count++;
    end
  endtask

  // Present one request, hold it until accepted, record its prediction
  task automatic issue_request(input voice_request_t rq, input logic typed,
                               input voice_reply_t typed_reply);
    voice_reply_t model_reply;
    req_ch.valid       <= 1'b1;
    req_ch.action      <= rq.action;
    req_ch.handle      <= rq.handle;
    req_ch.buffer_slot <= rq.buffer_slot;
    req_ch.name_found  <= rq.name_found;
    req_ch.gain        <= rq.gain;
    req_ch.looping     <= rq.looping;
    req_ch.keep        <= rq.keep;
    req_ch.ended_voice <= rq.ended_voice;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    model_reply = predict_voice_reply(rq);
    pending_replies.insert(pending_replies.size(), typed ? typed_reply : model_reply);
  endtask

  // Drop valid for a random burst now and then
  task automatic request_gap();
    if (!steady_tail && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Drain all replies, then write the device-ready register
  task automatic set_audio_ready(input logic value);
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.audio_ready <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    model_audio_ready = value;
  endtask

  // Reply side: check accepted replies, stall ready in random bursts
  initial begin
    voice_reply_t got;
    voice_reply_t want;
    int           stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.status        = rsp_ch.status;
        got.handle_out    = rsp_ch.handle_out;
        got.voice_index   = rsp_ch.voice_index;
        got.voice_command = rsp_ch.voice_command;
        got.buffer_out    = rsp_ch.buffer_out;
        got.gain_out      = rsp_ch.gain_out;
        got.loop_out      = rsp_ch.loop_out;
        got.finished      = rsp_ch.finished;
        got.playing_count = rsp_ch.playing_count;
        if (pending_replies.size() == 0) begin
          $error("reply with no request pending: status 0x%0h", got.status);
          mismatch_count++;
        end else begin
          want = pending_replies.pop_front();
          check_field("status", want.status, got.status);
          check_field("handle_out", want.handle_out, got.handle_out);
          check_field("voice_index", want.voice_index, got.voice_index);
          check_field("voice_command", want.voice_command, got.voice_command);
          check_field("buffer_out", want.buffer_out, got.buffer_out);
          check_field("gain_out", want.gain_out, got.gain_out);
          check_field("loop_out", want.loop_out, got.loop_out);
          check_field("finished", want.finished, got.finished);
          check_field("playing_count", want.playing_count, got.playing_count);
        end
      end
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!steady_tail && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 15);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Request side: reset, scripted rows, random phases, drain, verdict
  initial begin
    int i;
    int p;
    int n;
    for (i = 0; i < VOICES; i++) begin
      owner_tbl[i]    = '0;
      kept_tbl[i]     = 1'b0;
      loaded_tbl[i]   = 1'b0;
      sounding_tbl[i] = 1'b0;
      stamp_tbl[i]    = '0;
    end
    model_handle      = HANDLE_FIRST;
    next_stamp        = '0;
    model_audio_ready = 1'b0;
    mismatch_count    = 0;
    steady_tail       = 1'b0;

    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.action      <= ACT_PLAY;
    req_ch.handle      <= '0;
    req_ch.buffer_slot <= '0;
    req_ch.name_found  <= 1'b0;
    req_ch.gain        <= '0;
    req_ch.looping     <= 1'b0;
    req_ch.keep        <= 1'b0;
    req_ch.ended_voice <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.audio_ready <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // walk the scripted rows
    for (i = 0; i < SCRIPT_ROWS; i++) begin
      if (directed_script[i].cfg_row) begin
        set_audio_ready(directed_script[i].cfg_value);
      end else begin
        request_gap();
        issue_request(directed_script[i].rq, directed_script[i].typed,
                      directed_script[i].reply);
      end
    end

    // random phases, idling off for the final stretch
    for (p = 0; p < PHASES; p++) begin
      set_audio_ready(phase_plan[p].ready);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p * ITEMS_PER_PHASE + n >= PHASES * ITEMS_PER_PHASE - STEADY_ITEMS)
          steady_tail = 1'b1;
        request_gap();
        issue_request(random_request(phase_plan[p].keep_pct, phase_plan[p].stop_pct),
                      1'b0, IDLE_REPLY);
      end
    end

    // drain, then allow stray replies to show up
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** voice_allocator_with_stealing: PASSED **");
    end else begin
      $display("** voice_allocator_with_stealing: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("** voice_allocator_with_stealing: FAILED **");
    $finish;
  end

endmodule
